// File: rtl/iteev_pkg.sv
// Package with the shared types, codes and helper function of the expression evaluator.
`default_nettype none

package iteev_pkg;

   // Frame stack depth and the width of the nesting level.
   localparam int MAX_NEST = 8;
   localparam int LVL_W    = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

   // Token operation codes as they arrive on the request channel.
   typedef enum logic [3:0] {
      OP_END     = 4'd0,
      OP_OPERAND = 4'd1,
      OP_OPEN    = 4'd2,
      OP_CLOSE   = 4'd3,
      OP_NOT     = 4'd4,
      OP_OR      = 4'd5,
      OP_ADD     = 4'd6,
      OP_SUB     = 4'd7,
      OP_AND     = 4'd8,
      OP_XOR     = 4'd9,
      OP_GT      = 4'd10,
      OP_LT      = 4'd11,
      OP_EQ      = 4'd12,
      OP_NE      = 4'd13,
      OP_MUL     = 4'd14,
      OP_DIV     = 4'd15
   } op_type;

   // An empty high-level slot shares the code of the end token.
   localparam op_type HOP_NONE = OP_END;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_DIV_ZERO   = 2'd1,
      ST_NEST_OVF   = 2'd2,
      ST_UNBALANCED = 2'd3
   } status_type;

   // Pending low-level operator.
   typedef enum logic [1:0] {
      LOW_NONE = 2'd0,
      LOW_OR   = 2'd1,
      LOW_ADD  = 2'd2,
      LOW_SUB  = 2'd3
   } low_type;

   // Token class decided by the front end.
   typedef enum logic [2:0] {
      K_END,
      K_OPERAND,
      K_OPEN,
      K_CLOSE,
      K_NOT,
      K_LOW,
      K_HIGH
   } kind_type;

   // Pending operators of one frame.
   typedef struct packed {
      logic    inv;
      op_type  hop;
      low_type lop;
   } mark_type;

   // Classified token handed from the front end to the back end.
   typedef struct packed {
      kind_type    kind;
      op_type      op;
      logic [31:0] value;
   } token_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_POP,
      BK_DIV
   } back_state_type;

   // Combines the sum with the product under the pending low-level operator.
   function automatic logic [31:0] fold_frame(input low_type lop, input logic [31:0] sum,
                                              input logic [31:0] prod);
      logic [31:0] res;
      unique case (lop)
         LOW_OR:  res = sum | prod;
         LOW_ADD: res = sum + prod;
         LOW_SUB: res = sum - prod;
         default: res = prod;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/iteev_if.sv
// Request and response channel interfaces of the expression evaluator.
`default_nettype none

interface iteev_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         operation;
   logic signed [31:0] operand_value;

   modport source (output valid, output operation, output operand_value, input ready);
   modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface iteev_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] expression_value;
   logic [1:0]         status;

   modport source (output valid, output expression_value, output status, input ready);
   modport sink   (input valid, input expression_value, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/iteev_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
`default_nettype none

module iteev_front
   import iteev_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   iteev_req_if.sink  req_bus,
   output token_type  tok_head,
   output logic       tok_valid,
   input  wire logic  tok_pop
);

   token_type   q_ff [2];
   token_type   q_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   token_type   new_tok;
   logic        push;

   // Classify the incoming operation.
   always_comb begin
      new_tok.op    = op_type'(req_bus.operation);
      new_tok.value = req_bus.operand_value;
      unique case (op_type'(req_bus.operation))
         OP_END:                new_tok.kind = K_END;
         OP_OPERAND:            new_tok.kind = K_OPERAND;
         OP_OPEN:               new_tok.kind = K_OPEN;
         OP_CLOSE:              new_tok.kind = K_CLOSE;
         OP_NOT:                new_tok.kind = K_NOT;
         OP_OR, OP_ADD, OP_SUB: new_tok.kind = K_LOW;
         default:               new_tok.kind = K_HIGH;
      endcase
   end

   assign req_bus.ready = (cnt_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign tok_valid     = (cnt_ff != 2'd0);
   assign tok_head      = q_ff[0];

   // Two-entry queue; entry zero is the head.
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (tok_pop) begin
         q_in[0] = q_ff[1];
      end
      priority if (push && tok_pop) begin
         if (cnt_ff == 2'd1) begin
            q_in[0] = new_tok;
         end else begin
            q_in[1] = new_tok;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            q_in[0] = new_tok;
         end else begin
            q_in[1] = new_tok;
         end
         cnt_in = cnt_ff + 2'd1;
      end else if (tok_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/iteev_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module iteev_divider
   import iteev_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [31:0] res_ff, res_in;
   logic [32:0] rem_sh;
   logic [32:0] diff;

   assign rem_sh = {rem_ff, quo_ff[31]};
   assign diff   = rem_sh - {1'b0, div_ff};

   // One restoring step per cycle on magnitudes; sign applied at the end.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         div_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (32'd0 - quo_in) : quo_in;
         end
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

`default_nettype wire

// File: rtl/iteev_back.sv
// Back end: frame stack, operator evaluation and the registered response stage.
`default_nettype none

module iteev_back
   import iteev_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type tok_head,
   input  wire logic      tok_valid,
   output logic           tok_pop,
   iteev_rsp_if.source    rsp_bus
);

   back_state_type state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   status_type  sticky_ff, sticky_in;
   logic [31:0] cur_sum_ff, cur_sum_in;
   logic [31:0] cur_prod_ff, cur_prod_in;
   mark_type    cur_mark_ff, cur_mark_in;
   logic [31:0] tmp_ff, tmp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff, rsp_status_in;

   // Saved frames, one per open parenthesis.
   logic [31:0] stk_sum  [MAX_NEST];
   logic [31:0] stk_prod [MAX_NEST];
   mark_type    stk_mark [MAX_NEST];
   logic [31:0] rd_sum_ff, rd_prod_ff;
   mark_type    rd_mark_ff;
   logic        push_frame;
   logic [LVL_W-1:0] rd_addr;

   logic        out_free;
   logic        is_div_op;
   logic        div_start, div_done;
   logic [31:0] div_q;

   // Factor unit inputs and results.
   mark_type    f_mark;
   logic [31:0] f_prod, f_val, f_v, f_res;
   logic        f_divz, f_div;
   status_type  end_st;
   logic [31:0] cur_fold;

   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(MAX_NEST - 1);

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign cur_fold  = fold_frame(cur_mark_ff.lop, cur_sum_ff, cur_prod_ff);
   assign rd_addr   = lvl_ff - 1'b1;
   assign tok_pop   = (state_ff == BK_IDLE) && tok_valid &&
                      ((tok_head.kind != K_END) || out_free);

   // Select the frame and value that take a factor.
   always_comb begin
      if (state_ff == BK_POP) begin
         f_mark = rd_mark_ff;
         f_prod = rd_prod_ff;
         f_val  = tmp_ff;
      end else begin
         f_mark = cur_mark_ff;
         f_prod = cur_prod_ff;
         f_val  = tok_head.value;
      end
   end

   // Apply not and the pending high-level operator.
   always_comb begin
      f_v    = f_mark.inv ? {31'd0, (f_val == 32'd0)} : f_val;
      f_divz = (f_v == 32'd0);
      f_div  = (f_mark.hop == OP_DIV);
      unique case (f_mark.hop)
         OP_AND:  f_res = f_prod & f_v;
         OP_XOR:  f_res = f_prod ^ f_v;
         OP_GT:   f_res = {31'd0, ($signed(f_prod) > $signed(f_v))};
         OP_LT:   f_res = {31'd0, ($signed(f_prod) < $signed(f_v))};
         OP_EQ:   f_res = {31'd0, (f_prod == f_v)};
         OP_NE:   f_res = {31'd0, (f_prod != f_v)};
         OP_MUL:  f_res = f_prod * f_v;
         OP_DIV:  f_res = 32'd0;
         default: f_res = f_v;
      endcase
   end

   // Status of the end token.
   always_comb begin
      end_st = sticky_ff;
      if (sticky_ff == ST_OK && lvl_ff != '0) begin
         end_st = ST_UNBALANCED;
      end
   end

   // A factor that needs the divider.
   assign is_div_op = f_div && !f_divz;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (tok_pop) begin
               if (tok_head.kind == K_CLOSE && lvl_ff != '0) begin
                  state_in = BK_POP;
               end else if (tok_head.kind == K_OPERAND && is_div_op) begin
                  state_in = BK_DIV;
               end
            end
         end
         BK_POP: begin
            state_in = is_div_op ? BK_DIV : BK_IDLE;
         end
         BK_DIV: begin
            if (div_done) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      lvl_in        = lvl_ff;
      sticky_in     = sticky_ff;
      cur_sum_in    = cur_sum_ff;
      cur_prod_in   = cur_prod_ff;
      cur_mark_in   = cur_mark_ff;
      tmp_in        = tmp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      push_frame    = 1'b0;
      div_start     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (tok_pop) begin
               unique case (tok_head.kind)
                  K_END: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = end_st;
                     rsp_value_in  = (end_st != ST_NEST_OVF && end_st != ST_UNBALANCED &&
                                      lvl_ff == '0) ? cur_fold : 32'd0;
                     lvl_in        = '0;
                     sticky_in     = ST_OK;
                     cur_mark_in   = '0;
                  end
                  K_OPERAND: begin
                     cur_mark_in.hop = HOP_NONE;
                     cur_mark_in.inv = 1'b0;
                     if (is_div_op) begin
                        div_start = 1'b1;
                     end else begin
                        cur_prod_in = f_res;
                        if (f_div && sticky_ff == ST_OK) begin
                           sticky_in = ST_DIV_ZERO;
                        end
                     end
                  end
                  K_OPEN: begin
                     if (lvl_ff == LVL_TOP) begin
                        if (sticky_ff == ST_OK) begin
                           sticky_in = ST_NEST_OVF;
                        end
                     end else begin
                        push_frame  = 1'b1;
                        lvl_in      = lvl_ff + 1'b1;
                        cur_sum_in  = '0;
                        cur_prod_in = '0;
                        cur_mark_in = '0;
                     end
                  end
                  K_CLOSE: begin
                     if (lvl_ff == '0) begin
                        if (sticky_ff == ST_OK) begin
                           sticky_in = ST_UNBALANCED;
                        end
                     end else begin
                        tmp_in = cur_fold;
                     end
                  end
                  K_NOT: begin
                     cur_mark_in.inv = !cur_mark_ff.inv;
                  end
                  K_LOW: begin
                     cur_sum_in      = cur_fold;
                     cur_mark_in.hop = HOP_NONE;
                     cur_mark_in.lop = low_type'(tok_head.op - OP_NOT);
                  end
                  default: begin
                     cur_mark_in.hop = tok_head.op;
                  end
               endcase
            end
         end
         BK_POP: begin
            // Restore the enclosing frame and take the closed value as its factor.
            lvl_in          = lvl_ff - 1'b1;
            cur_sum_in      = rd_sum_ff;
            cur_prod_in     = rd_prod_ff;
            cur_mark_in     = rd_mark_ff;
            cur_mark_in.hop = HOP_NONE;
            cur_mark_in.inv = 1'b0;
            if (is_div_op) begin
               div_start = 1'b1;
            end else begin
               cur_prod_in = f_res;
               if (f_div && sticky_ff == ST_OK) begin
                  sticky_in = ST_DIV_ZERO;
               end
            end
         end
         BK_DIV: begin
            if (div_done) begin
               cur_prod_in = div_q;
            end
         end
         default: begin
            cur_mark_in = cur_mark_ff;
         end
      endcase
   end

   iteev_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (f_prod),
      .divisor  (f_v),
      .done     (div_done),
      .quotient (div_q)
   );

   // Frame stack memory with a registered read of the enclosing frame.
   always_ff @(posedge clock) begin
      if (push_frame) begin
         stk_sum[lvl_ff]  <= cur_sum_ff;
         stk_prod[lvl_ff] <= cur_prod_ff;
         stk_mark[lvl_ff] <= cur_mark_ff;
      end
      rd_sum_ff  <= stk_sum[rd_addr];
      rd_prod_ff <= stk_prod[rd_addr];
      rd_mark_ff <= stk_mark[rd_addr];
   end

   always_ff @(posedge clock) begin
      cur_sum_ff    <= cur_sum_in;
      cur_prod_ff   <= cur_prod_in;
      tmp_ff        <= tmp_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         lvl_ff       <= '0;
         sticky_ff    <= ST_OK;
         cur_mark_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         sticky_ff    <= sticky_in;
         cur_mark_ff  <= cur_mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.expression_value = rsp_value_ff;
   assign rsp_bus.status           = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/infix_token_expression_evaluator.sv
// Top level of the infix token expression evaluator.
//
//   Channel   Direction  Carries
//   req_bus   in         operation, operand_value (one token per beat)
//   rsp_bus   out        expression_value, status (one beat per end token)
//
// A two-entry queue separates the front end from the back end, and the
// response sits in its own register, so new tokens are taken while a result waits.
// Most tokens finish in the idle state; a close passes the pop state (registered
// stack read), and a division waits on the one-bit-per-cycle divider.
// Reset is synchronous and returns the evaluator to an empty expression.
`default_nettype none

module infix_token_expression_evaluator
   import iteev_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   iteev_req_if.sink   req_bus,
   iteev_rsp_if.source rsp_bus
);

   token_type tok_head;
   logic      tok_valid;
   logic      tok_pop;

   iteev_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .tok_head  (tok_head),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop)
   );

   iteev_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_head  (tok_head),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
